>>> sv/ttc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile triangle coverage package
// Word types, register indexes and shared constants for the tile coverage
// rasterizer.
// ----------------------------------------------------------------------------
package ttc_pkg;

    localparam int DEF_TILE_SIZE = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TILE_LEFT      = 2'd0,
        REG_TILE_TOP       = 2'd1,
        REG_CULL_THRESHOLD = 2'd2,
        REG_HALF_PIXEL     = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        CULL_NONE    = 2'd0,
        CULL_SMALL   = 2'd1,
        CULL_WIND_A  = 2'd2,
        CULL_WIND_B  = 2'd3
    } cull_mode_t;

    typedef struct packed {
        logic signed [15:0] x1;
        logic signed [15:0] y1;
        logic signed [15:0] x2;
        logic signed [15:0] y2;
        logic signed [15:0] x3;
        logic signed [15:0] y3;
        logic signed [15:0] x4;
        logic signed [15:0] y4;
        logic               is_quad;
        logic               strip_parity;
        logic [1:0]         cull_mode;
        logic [31:0]        prim_tag;
    } in_word_t;

    typedef struct packed {
        logic [4:0]  row_index;
        logic [31:0] coverage;
        logic [31:0] tag_out;
        logic        culled;
        logic        last;
    } out_word_t;

endpackage

>>> sv/tile_triangle_coverage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile triangle coverage
// Half-space edge function rasterizer: culls a triangle or quad, clamps its
// bounding box to one tile and emits one coverage word per tile row, a single word if culled.
// ----------------------------------------------------------------------------
// A shape moves through setup stages 1-4, the row generator and the output register.
// A visible shape occupies the row generator for min(TILE_SIZE,32) rows, one
// row word per cycle unless out_ready stalls it; a culled shape yields one word.
// The four setup stages overlap the row generator, so shapes follow back to back.
// Reset: rst_n clears all valid bits and the configuration registers to zero.
module tile_triangle_coverage #(
    parameter int TILE_SIZE = ttc_pkg::DEF_TILE_SIZE
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  ttc_pkg::in_word_t             in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ttc_pkg::out_word_t            out_data,
    input  logic                          cfg_we,
    input  logic [ttc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ttc_pkg::CFG_DATA_W-1:0] cfg_data
);

    // Rows (and columns) reported per shape, and the local offset widths.
    localparam int ROWS = (TILE_SIZE < 32) ? TILE_SIZE : 32;
    localparam int RCW  = $clog2(ROWS);
    localparam int LW   = $clog2(TILE_SIZE);
    localparam int EW   = 40;

    // ------------------------------------------------------------------
    // Config regs: user must change them only while block is idle; not enforced.
    // ------------------------------------------------------------------
    logic [11:0] tile_left_reg;
    logic [11:0] tile_top_reg;
    logic [15:0] cull_thr_reg;
    logic        half_pixel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_left_reg  <= '0;
            tile_top_reg   <= '0;
            cull_thr_reg   <= '0;
            half_pixel_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (ttc_pkg::cfg_index_t'(cfg_index))
                ttc_pkg::REG_TILE_LEFT:      tile_left_reg  <= cfg_data[11:0];
                ttc_pkg::REG_TILE_TOP:       tile_top_reg   <= cfg_data[11:0];
                ttc_pkg::REG_CULL_THRESHOLD: cull_thr_reg   <= cfg_data;
                ttc_pkg::REG_HALF_PIXEL:     half_pixel_reg <= cfg_data[0];
                default:                     ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake. Each setup stage moves on when the next one is
    // empty or moving too; the last one empties into the row generator.
    // ------------------------------------------------------------------
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    logic adv1, adv2, adv3, load;
    logic in_acc;

    logic act_reg;
    logic [RCW-1:0] row_reg;
    logic culled_reg;
    logic out_v_reg;
    logic out_can, emit, last_row;

    assign out_can  = !out_v_reg || out_ready;
    assign emit     = act_reg && out_can;
    assign last_row = culled_reg || (row_reg == RCW'(ROWS - 1));
    assign load     = s4_v_reg && (!act_reg || (emit && last_row));
    assign adv3     = s3_v_reg && (!s4_v_reg || load);
    assign adv2     = s2_v_reg && (!s3_v_reg || adv3);
    assign adv1     = s1_v_reg && (!s2_v_reg || adv2);
    assign in_ready = !s1_v_reg || adv1;
    assign in_acc   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= in_acc || (s1_v_reg && !adv1);
            s2_v_reg <= adv1 || (s2_v_reg && !adv2);
            s3_v_reg <= adv2 || (s3_v_reg && !adv3);
            s4_v_reg <= adv3 || (s4_v_reg && !load);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: the accepted word.
    // ------------------------------------------------------------------
    ttc_pkg::in_word_t s1_reg;

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_reg <= in_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 to 2: differences, sample origin offsets and the raw
    // bounding box in pixels.
    // ------------------------------------------------------------------
    logic signed [15:0] vx [4];
    logic signed [15:0] vy [4];
    logic signed [17:0] sx0, sy0;
    logic signed [15:0] mnx, mny, mxx, mxy;
    logic signed [16:0] mxx16, mxy16;

    logic signed [16:0] s2_dx_next [4];
    logic signed [16:0] s2_dy_next [4];
    logic signed [17:0] s2_a_next  [4];
    logic signed [17:0] s2_b_next  [4];
    logic signed [16:0] s2_ad_next [4];
    logic signed [13:0] s2_minx_next, s2_miny_next, s2_maxx_next, s2_maxy_next;

    always_comb
    begin
        vx[0] = s1_reg.x1; vy[0] = s1_reg.y1;
        vx[1] = s1_reg.x2; vy[1] = s1_reg.y2;
        vx[2] = s1_reg.x3; vy[2] = s1_reg.y3;
        vx[3] = s1_reg.x4; vy[3] = s1_reg.y4;
        sx0 = $signed({2'b00, tile_left_reg, 4'b0000}) + (half_pixel_reg ? 18'sd8 : 18'sd0);
        sy0 = $signed({2'b00, tile_top_reg, 4'b0000}) + (half_pixel_reg ? 18'sd8 : 18'sd0);
        for (int i = 0; i < 4; i++)
        begin
            s2_a_next[i] = 18'(vx[i]) - sx0;
            s2_b_next[i] = 18'(vy[i]) - sy0;
        end
        // Edges run 1-2, 2-3, then 3-4 and 4-1 for a quad or 3-1 otherwise.
        s2_dx_next[0] = 17'(vx[0]) - 17'(vx[1]);
        s2_dy_next[0] = 17'(vy[0]) - 17'(vy[1]);
        s2_dx_next[1] = 17'(vx[1]) - 17'(vx[2]);
        s2_dy_next[1] = 17'(vy[1]) - 17'(vy[2]);
        s2_dx_next[2] = 17'(vx[2]) - (s1_reg.is_quad ? 17'(vx[3]) : 17'(vx[0]));
        s2_dy_next[2] = 17'(vy[2]) - (s1_reg.is_quad ? 17'(vy[3]) : 17'(vy[0]));
        s2_dx_next[3] = 17'(vx[3]) - 17'(vx[0]);
        s2_dy_next[3] = 17'(vy[3]) - 17'(vy[0]);
        // Area operands: (x1-x3), (y2-y3), (y1-y3), (x2-x3).
        s2_ad_next[0] = 17'(vx[0]) - 17'(vx[2]);
        s2_ad_next[1] = 17'(vy[1]) - 17'(vy[2]);
        s2_ad_next[2] = 17'(vy[0]) - 17'(vy[2]);
        s2_ad_next[3] = 17'(vx[1]) - 17'(vx[2]);

        mnx = (vx[0] < vx[1]) ? vx[0] : vx[1];
        mnx = (mnx < vx[2]) ? mnx : vx[2];
        mny = (vy[0] < vy[1]) ? vy[0] : vy[1];
        mny = (mny < vy[2]) ? mny : vy[2];
        mxx = (vx[0] > vx[1]) ? vx[0] : vx[1];
        mxx = (mxx > vx[2]) ? mxx : vx[2];
        mxy = (vy[0] > vy[1]) ? vy[0] : vy[1];
        mxy = (mxy > vy[2]) ? mxy : vy[2];
        // Minimum edge rounds down; maximum edge plus one pixel truncates.
        s2_minx_next = 14'(mnx >>> 4);
        s2_miny_next = 14'(mny >>> 4);
        mxx16 = 17'(mxx) + 17'sd16;
        mxy16 = 17'(mxy) + 17'sd16;
        s2_maxx_next = (mxx16 < 0) ? 14'((mxx16 + 17'sd15) >>> 4) : 14'(mxx16 >>> 4);
        s2_maxy_next = (mxy16 < 0) ? 14'((mxy16 + 17'sd15) >>> 4) : 14'(mxy16 >>> 4);
    end

    logic signed [16:0] s2_dx_reg [4];
    logic signed [16:0] s2_dy_reg [4];
    logic signed [17:0] s2_a_reg  [4];
    logic signed [17:0] s2_b_reg  [4];
    logic signed [16:0] s2_ad_reg [4];
    logic signed [13:0] s2_minx_reg, s2_miny_reg, s2_maxx_reg, s2_maxy_reg;
    logic               s2_quad_reg, s2_par_reg;
    logic [1:0]         s2_mode_reg;
    logic [31:0]        s2_tag_reg;

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s2_dx_reg   <= s2_dx_next;
            s2_dy_reg   <= s2_dy_next;
            s2_a_reg    <= s2_a_next;
            s2_b_reg    <= s2_b_next;
            s2_ad_reg   <= s2_ad_next;
            s2_minx_reg <= s2_minx_next;
            s2_miny_reg <= s2_miny_next;
            s2_maxx_reg <= s2_maxx_next;
            s2_maxy_reg <= s2_maxy_next;
            s2_quad_reg <= s1_reg.is_quad;
            s2_par_reg  <= s1_reg.strip_parity;
            s2_mode_reg <= s1_reg.cull_mode;
            s2_tag_reg  <= s1_reg.prim_tag;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2 to 3: products and the box clamped to the tile, expressed
    // as local column and row offsets.
    // ------------------------------------------------------------------
    logic signed [13:0] lft, top, hix, hiy, cminx, cmaxx, cminy, cmaxy;
    logic signed [34:0] s3_p_next [4];
    logic signed [34:0] s3_q_next [4];
    logic signed [33:0] s3_ar0_next, s3_ar1_next;

    always_comb
    begin
        lft = $signed({2'b00, tile_left_reg});
        top = $signed({2'b00, tile_top_reg});
        hix = lft + 14'(TILE_SIZE - 1);
        hiy = top + 14'(TILE_SIZE - 1);
        cminx = (s2_minx_reg < lft) ? lft : s2_minx_reg;
        cminy = (s2_miny_reg < top) ? top : s2_miny_reg;
        cmaxx = (s2_maxx_reg > hix) ? hix : s2_maxx_reg;
        cmaxy = (s2_maxy_reg > hiy) ? hiy : s2_maxy_reg;
        for (int i = 0; i < 4; i++)
        begin
            s3_p_next[i] = 35'(s2_dy_reg[i]) * 35'(s2_a_reg[i]);
            s3_q_next[i] = 35'(s2_dx_reg[i]) * 35'(s2_b_reg[i]);
        end
        s3_ar0_next = 34'(s2_ad_reg[0]) * 34'(s2_ad_reg[1]);
        s3_ar1_next = 34'(s2_ad_reg[2]) * 34'(s2_ad_reg[3]);
    end

    logic signed [34:0] s3_p_reg [4];
    logic signed [34:0] s3_q_reg [4];
    logic signed [33:0] s3_ar0_reg, s3_ar1_reg;
    logic signed [16:0] s3_dx_reg [4];
    logic signed [16:0] s3_dy_reg [4];
    logic [LW-1:0]      s3_cmin_reg, s3_cmax_reg, s3_rmin_reg, s3_rmax_reg;
    logic               s3_empty_reg, s3_quad_reg, s3_par_reg;
    logic [1:0]         s3_mode_reg;
    logic [31:0]        s3_tag_reg;

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            s3_p_reg     <= s3_p_next;
            s3_q_reg     <= s3_q_next;
            s3_ar0_reg   <= s3_ar0_next;
            s3_ar1_reg   <= s3_ar1_next;
            s3_dx_reg    <= s2_dx_reg;
            s3_dy_reg    <= s2_dy_reg;
            s3_cmin_reg  <= LW'(cminx - lft);
            s3_cmax_reg  <= LW'(cmaxx - lft);
            s3_rmin_reg  <= LW'(cminy - top);
            s3_rmax_reg  <= LW'(cmaxy - top);
            s3_empty_reg <= (cmaxx < cminx) || (cmaxy < cminy);
            s3_quad_reg  <= s2_quad_reg;
            s3_par_reg   <= s2_par_reg;
            s3_mode_reg  <= s2_mode_reg;
            s3_tag_reg   <= s2_tag_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3 to 4: signed area and the edge values at the tile's first
    // sample, e = dy*(px-sx) - dx*(py-sy).
    // ------------------------------------------------------------------
    logic signed [EW-1:0] s4_base_reg [4];
    logic signed [34:0]   s4_area_reg;
    logic signed [16:0]   s4_dx_reg [4];
    logic signed [16:0]   s4_dy_reg [4];
    logic [LW-1:0]        s4_cmin_reg, s4_cmax_reg, s4_rmin_reg, s4_rmax_reg;
    logic                 s4_empty_reg, s4_quad_reg, s4_par_reg;
    logic [1:0]           s4_mode_reg;
    logic [31:0]          s4_tag_reg;

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            for (int i = 0; i < 4; i++)
            begin
                s4_base_reg[i] <= EW'(s3_p_reg[i]) - EW'(s3_q_reg[i]);
            end
            s4_area_reg  <= 35'(s3_ar0_reg) - 35'(s3_ar1_reg);
            s4_dx_reg    <= s3_dx_reg;
            s4_dy_reg    <= s3_dy_reg;
            s4_cmin_reg  <= s3_cmin_reg;
            s4_cmax_reg  <= s3_cmax_reg;
            s4_rmin_reg  <= s3_rmin_reg;
            s4_rmax_reg  <= s3_rmax_reg;
            s4_empty_reg <= s3_empty_reg;
            s4_quad_reg  <= s3_quad_reg;
            s4_par_reg   <= s3_par_reg;
            s4_mode_reg  <= s3_mode_reg;
            s4_tag_reg   <= s3_tag_reg;
        end
    end

    // Culling decision, taken as the shape enters the row generator.
    logic [34:0] area_mag;
    logic        wind_m, cull_small, cull_wind, s4_culled;

    always_comb
    begin
        area_mag   = (s4_area_reg < 0) ? 35'(-s4_area_reg) : 35'(s4_area_reg);
        cull_small = (ttc_pkg::cull_mode_t'(s4_mode_reg) != ttc_pkg::CULL_NONE)
                     && (area_mag < 35'(cull_thr_reg));
        wind_m     = s4_par_reg ^ s4_mode_reg[0];
        cull_wind  = ((ttc_pkg::cull_mode_t'(s4_mode_reg) == ttc_pkg::CULL_WIND_A)
                      || (ttc_pkg::cull_mode_t'(s4_mode_reg) == ttc_pkg::CULL_WIND_B))
                     && ((!wind_m && (s4_area_reg < 0)) || (wind_m && (s4_area_reg > 0)));
        s4_culled  = cull_small || cull_wind || s4_empty_reg;
    end

    // ------------------------------------------------------------------
    // Row generator: holds one shape, steps the edge values by one row per
    // emitted word and evaluates every column of the current row.
    // ------------------------------------------------------------------
    logic signed [EW-1:0] base_reg [4];
    logic signed [16:0]   dx_reg [4];
    logic signed [16:0]   dy_reg [4];
    logic [LW-1:0]        cmin_reg, cmax_reg, rmin_reg, rmax_reg;
    logic                 quad_reg, flip_reg;
    logic [31:0]          tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg    <= 1'b0;
            row_reg    <= '0;
            culled_reg <= 1'b0;
        end
        else if (load)
        begin
            act_reg    <= 1'b1;
            row_reg    <= '0;
            culled_reg <= s4_culled;
        end
        else if (emit)
        begin
            act_reg <= !last_row;
            row_reg <= row_reg + RCW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            base_reg <= s4_base_reg;
            dx_reg   <= s4_dx_reg;
            dy_reg   <= s4_dy_reg;
            cmin_reg <= s4_cmin_reg;
            cmax_reg <= s4_cmax_reg;
            rmin_reg <= s4_rmin_reg;
            rmax_reg <= s4_rmax_reg;
            quad_reg <= s4_quad_reg;
            flip_reg <= s4_area_reg > 0;
            tag_reg  <= s4_tag_reg;
        end
        else if (emit)
        begin
            for (int i = 0; i < 4; i++)
            begin
                base_reg[i] <= base_reg[i] + (EW'(dx_reg[i]) <<< 4);
            end
        end
    end

    // Coverage of the current row. Edge values for column j drop by 16*dy*j.
    logic [31:0]          mask;
    logic                 row_in, col_ok;
    logic signed [EW-1:0] ev;
    logic [LW:0]          row_l;

    always_comb
    begin
        mask   = '0;
        row_l  = (LW+1)'(row_reg);
        row_in = (row_l >= (LW+1)'(rmin_reg)) && (row_l <= (LW+1)'(rmax_reg));
        ev     = '0;
        col_ok = 1'b0;
        for (int j = 0; j < ROWS; j++)
        begin
            col_ok = row_in && (LW'(j) >= cmin_reg) && (LW'(j) <= cmax_reg);
            for (int i = 0; i < 4; i++)
            begin
                ev = base_reg[i] - ((EW'(dy_reg[i]) * EW'(j)) <<< 4);
                if ((i < 3 || quad_reg) && (flip_reg ? (ev > 0) : (ev < 0)))
                begin
                    col_ok = 1'b0;
                end
            end
            mask[j] = col_ok;
        end
    end

    // Output register.
    ttc_pkg::out_word_t out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_v_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg.row_index <= culled_reg ? 5'd0 : 5'(row_reg);
            out_reg.coverage  <= culled_reg ? 32'd0 : mask;
            out_reg.tag_out   <= tag_reg;
            out_reg.culled    <= culled_reg;
            out_reg.last      <= last_row;
        end
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

`ifndef SYNTH
    // A culled word is always a single, final, empty word.
    a_culled_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.culled) |-> (out_data.last && (out_data.coverage == 32'd0)))
        else $error("culled word is not a lone empty last word");

    // A visible shape ends exactly on its last reported row.
    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.culled) |->
            (out_data.last == (out_data.row_index == 5'(ROWS - 1))))
        else $error("last flag does not match the final row");

    // The row generator only takes a new shape when the old one is done.
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (load && act_reg) |-> (emit && last_row))
        else $error("new shape loaded over a shape in progress");
`endif

endmodule
